// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check of a property on the rising clock edge, off during reset
`define CHK_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// implication checked on the rising clock edge, off during reset
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/ajb_pkg.sv =====
// shared constants and types of the audio jitter buffer
package ajb_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SLOT_W  = 32 + 64 + 16;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_LATE      = 3'd1;
    localparam logic [2:0] ST_WINDOW    = 3'd2;
    localparam logic [2:0] ST_BUFFERING = 3'd3;
    localparam logic [2:0] ST_UNDERRUN  = 3'd4;
    localparam logic [2:0] ST_PLAYED    = 3'd5;
    localparam logic [2:0] ST_SILENCE   = 3'd6;

    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_PERIOD = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SREAD,
        S_SUB,
        S_SCAN,
        S_SCAN_RD,
        S_DONE
    } fsm_t;

endpackage

// ===== src/ajb_ram.sv =====
// generic single port ram with registered read
module ajb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== src/audio_jitter_buffer.sv =====
// Audio jitter buffer: reorders packets by sequence number in a 64 slot ring memory and
// conceals missing packets with silence. One item is taken at a time. A push, a clear or a
// played pop goes through the states S_EXEC and S_DONE. A concealed pop adds S_SREAD and
// S_SUB when a later packet is held. A pop that plays the lowest held packet then scans
// the slot valid bits one per cycle for the next held one, up to 63 more slots, and then
// reads that slot in S_SCAN_RD. Slot data memory has a single port.
// The result waits in an output register while the next item is taken.
module audio_jitter_buffer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] seq,
    input  logic [63:0] timestamp,
    input  logic [15:0] payload_handle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] out_seq,
    output logic [63:0] out_timestamp,
    output logic [15:0] out_handle
);
    import ajb_pkg::*;
    `include "assert_macros.svh"

    fsm_t state_reg, state_next;

    logic [6:0]  target_reg;
    logic [15:0] period_reg;

    logic [DEPTH-1:0] valid_reg;
    logic             buffering_reg;
    logic [31:0]      play_reg;
    logic [31:0]      lo_reg;
    logic [31:0]      hi_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [1:0]  op_reg;
    logic [31:0] seq_reg;
    logic [63:0] ts_reg;
    logic [15:0] hdl_reg;

    logic [2:0]  res_status_reg;
    logic [31:0] res_seq_reg;
    logic [63:0] res_ts_reg;
    logic [15:0] res_hdl_reg;
    logic [31:0] diff_reg;
    logic [47:0] prod_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [CNT_W-1:0] scan_k_reg;

    logic             out_valid_reg;
    logic [2:0]       out_status_reg;
    logic [31:0]      out_seq_reg;
    logic [63:0]      out_ts_reg;
    logic [15:0]      out_hdl_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_addr;
    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;
    logic [31:0]       rd_seq;
    logic [63:0]       rd_ts;
    logic [15:0]       rd_hdl;

    logic [IDX_W-1:0] push_idx;
    logic [IDX_W-1:0] play_idx;
    logic [IDX_W-1:0] scan_pos;
    logic [31:0]      new_lo;
    logic [31:0]      new_hi;
    logic [32:0]      span1;
    logic [7:0]       tgt;

    assign rd_seq   = ram_rdata[SLOT_W-1 -: 32];
    assign rd_ts    = ram_rdata[79:16];
    assign rd_hdl   = ram_rdata[15:0];
    assign push_idx = seq_reg[IDX_W-1:0];
    assign play_idx = play_reg[IDX_W-1:0];
    assign scan_pos = scan_idx_reg + scan_k_reg[IDX_W-1:0];

    assign new_lo = (cnt_reg == '0) ? seq_reg : ((seq_reg < lo_reg) ? seq_reg : lo_reg);
    assign new_hi = (cnt_reg == '0) ? seq_reg : ((seq_reg > hi_reg) ? seq_reg : hi_reg);
    assign span1  = {1'b0, new_hi - new_lo} + 33'd1;
    assign tgt    = ({1'b0, target_reg} < 8'(DEPTH)) ? {1'b0, target_reg} : 8'(DEPTH);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = play_idx;
        ram_wdata = {seq_reg, ts_reg, hdl_reg};
        case (state_reg)
            S_EXEC:
            begin
                if (op_reg == OP_PUSH)
                begin
                    ram_addr = push_idx;
                    ram_we   = !(!buffering_reg && seq_reg < play_reg)
                               && !(cnt_reg != '0 && (new_hi - new_lo) >= 32'(DEPTH));
                end
                else
                begin
                    ram_addr = lo_reg[IDX_W-1:0];
                end
            end
            S_SCAN:
            begin
                ram_addr = scan_pos;
            end
            default:
            begin
                ram_addr = play_idx;
            end
        endcase
    end

    ajb_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 7'd8;
            period_reg <= 16'd5333;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET: target_reg <= cfg_data[6:0];
                CFG_PERIOD: period_reg <= cfg_data;
                default:    period_reg <= period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                if (op_reg == OP_POP && !buffering_reg && cnt_reg != '0)
                begin
                    if (valid_reg[play_idx] && rd_seq == play_reg)
                    begin
                        if (cnt_reg != CNT_W'(1) && lo_reg == play_reg)
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (lo_reg > play_reg)
                    begin
                        state_next = S_SREAD;
                    end
                end
            end
            S_SREAD:   state_next = S_SUB;
            S_SUB:     state_next = S_DONE;
            S_SCAN:
            begin
                if (valid_reg[scan_pos])
                begin
                    state_next = S_SCAN_RD;
                end
                else if (scan_k_reg == CNT_W'(DEPTH - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_RD: state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            buffering_reg <= 1'b1;
            play_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            scan_k_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_EXEC:
                begin
                    if (op_reg == OP_PUSH)
                    begin
                        if (ram_we)
                        begin
                            if (!valid_reg[push_idx])
                            begin
                                cnt_reg <= cnt_reg + CNT_W'(1);
                            end
                            valid_reg[push_idx] <= 1'b1;
                            lo_reg <= new_lo;
                            hi_reg <= new_hi;
                            if (buffering_reg && span1 >= {25'd0, tgt})
                            begin
                                buffering_reg <= 1'b0;
                                play_reg      <= new_lo;
                            end
                            else if (buffering_reg && cnt_reg == '0)
                            begin
                                play_reg <= seq_reg;
                            end
                        end
                        else if (buffering_reg && cnt_reg == '0)
                        begin
                            play_reg <= seq_reg;
                        end
                    end
                    else if (op_reg == OP_POP)
                    begin
                        if (!buffering_reg)
                        begin
                            if (cnt_reg == '0)
                            begin
                                buffering_reg <= 1'b1;
                            end
                            else
                            begin
                                play_reg <= play_reg + 32'd1;
                                if (valid_reg[play_idx] && rd_seq == play_reg)
                                begin
                                    valid_reg[play_idx] <= 1'b0;
                                    cnt_reg <= cnt_reg - CNT_W'(1);
                                    scan_k_reg <= CNT_W'(1);
                                    if (cnt_reg == CNT_W'(1))
                                    begin
                                        lo_reg <= '0;
                                        hi_reg <= '0;
                                    end
                                end
                            end
                        end
                    end
                    else
                    begin
                        valid_reg     <= '0;
                        buffering_reg <= 1'b1;
                        play_reg      <= '0;
                        lo_reg        <= '0;
                        hi_reg        <= '0;
                        cnt_reg       <= '0;
                    end
                end
                S_SCAN:
                begin
                    scan_k_reg <= scan_k_reg + CNT_W'(1);
                end
                S_SCAN_RD:
                begin
                    lo_reg <= rd_seq;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    scan_k_reg <= scan_k_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg  <= op;
                seq_reg <= seq;
                ts_reg  <= timestamp;
                hdl_reg <= payload_handle;
            end
            S_EXEC:
            begin
                res_seq_reg  <= '0;
                res_ts_reg   <= '0;
                res_hdl_reg  <= '0;
                scan_idx_reg <= play_idx;
                diff_reg     <= lo_reg - play_reg;
                if (op_reg == OP_PUSH)
                begin
                    if (!buffering_reg && seq_reg < play_reg)
                    begin
                        res_status_reg <= ST_LATE;
                    end
                    else if (!ram_we)
                    begin
                        res_status_reg <= ST_WINDOW;
                    end
                    else
                    begin
                        res_status_reg <= ST_STORED;
                    end
                end
                else if (op_reg == OP_POP)
                begin
                    if (buffering_reg)
                    begin
                        res_status_reg <= ST_BUFFERING;
                    end
                    else if (cnt_reg == '0)
                    begin
                        res_status_reg <= ST_UNDERRUN;
                    end
                    else if (valid_reg[play_idx] && rd_seq == play_reg)
                    begin
                        res_status_reg <= ST_PLAYED;
                        res_seq_reg    <= play_reg;
                        res_ts_reg     <= rd_ts;
                        res_hdl_reg    <= rd_hdl;
                    end
                    else
                    begin
                        res_status_reg <= ST_SILENCE;
                        res_seq_reg    <= play_reg;
                    end
                end
                else
                begin
                    res_status_reg <= ST_BUFFERING;
                end
            end
            S_SREAD:
            begin
                res_ts_reg <= rd_ts;
                prod_reg   <= diff_reg * period_reg;
            end
            S_SUB:
            begin
                res_ts_reg <= res_ts_reg - {16'd0, prod_reg};
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_status_reg <= res_status_reg;
                    out_seq_reg    <= res_seq_reg;
                    out_ts_reg     <= res_ts_reg;
                    out_hdl_reg    <= res_hdl_reg;
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign out_seq       = out_seq_reg;
    assign out_timestamp = out_ts_reg;
    assign out_handle    = out_hdl_reg;

    `CHK_PROP(a_cnt_range, (cnt_reg <= CNT_W'(DEPTH)), "held count beyond depth")
    `CHK_PROP(a_cnt_match, ($countones(valid_reg) == 32'(cnt_reg)), "held count off valid bits")
    `CHK_IMPL(a_quiet_fields,
        out_valid && status != ST_PLAYED && status != ST_SILENCE,
        out_seq == '0 && out_timestamp == '0 && out_handle == '0,
        "nonzero fields on a non-play result")
    `CHK_IMPL(a_silence_handle, out_valid && status == ST_SILENCE, out_handle == '0,
        "silence with a handle")
endmodule
